@@ hdl/mppt_incremental_conductance_macros.svh @@
`ifndef MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH
`define MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define MPPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define MPPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mppt_ic_pkg.sv @@
`timescale 1ns / 1ps

package mppt_ic_pkg;

	localparam int DataW = 16;
	localparam int CfgIdxW = 8;

	localparam logic [CfgIdxW-1:0] REG_STEP_SIZE = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_DUTY = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_MIN_DUTY = 8'd3;

	localparam logic [DataW-1:0] STEP_SIZE_RST = 16'd655;
	localparam logic [DataW-1:0] TOLERANCE_RST = 16'd16;
	localparam logic [DataW-1:0] MAX_DUTY_RST = 16'd62258;
	localparam logic [DataW-1:0] MIN_DUTY_RST = 16'd3277;

	typedef enum logic [1:0] {
		DIR_HOLD = 2'd0,
		DIR_UP = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_MUL_D,
		ST_CMP,
		ST_STEP,
		ST_DONE
	} state_t;

endpackage

@@ hdl/mppt_ic_if.sv @@
`timescale 1ns / 1ps

interface mppt_ic_sample_if;
	logic valid;
	logic ready;
	logic [15:0] bus_voltage_mv;
	logic signed [15:0] current_ma;

	modport source (output valid, output bus_voltage_mv, output current_ma, input ready);
	modport sink (input valid, input bus_voltage_mv, input current_ma, output ready);
endinterface

interface mppt_ic_result_if;
	logic valid;
	logic ready;
	logic [15:0] duty;
	logic [1:0] direction;

	modport source (output valid, output duty, output direction, input ready);
	modport sink (input valid, input duty, input direction, output ready);
endinterface

interface mppt_ic_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/mppt_incremental_conductance.sv @@
`timescale 1ns / 1ps
// Incremental-conductance MPPT.
// sample (sink): one beat per panel sample, bus voltage in mV and signed current in mA.
// result (source): one beat per sample, the new Q0.16 duty and the step direction.
// cfg (sink): register writes, always ready; index 0 step, 1 tolerance, 2 max, 3 min duty.
// Writes with any other index are dropped. Write registers only while the block is idle.
// A sample with a changed voltage runs the four multiply steps, the compare, the step
// and the done state; an unchanged or zero voltage goes straight to the step and done
// states. One 35x18 multiplier is reused for the four products of the conductance test,
// each product registered before the next. sample.ready is high only while the sequencer
// is idle, so a new sample is taken only once the previous one has left the sequencer.
// The result sits in an output register: the next sample is taken while it waits, and
// the sequencer stalls in its last step only if the previous beat is still untaken.
// Reset clears the stored sample and the duty to zero, loads the register defaults and
// empties the output register.
module mppt_incremental_conductance (
	input logic clk,
	input logic arst_n,
	mppt_ic_sample_if.sink sample,
	mppt_ic_result_if.source result,
	mppt_ic_cfg_if.sink cfg
);
	import mppt_ic_pkg::*;

	`include "mppt_incremental_conductance_macros.svh"

	state_t state_q, state_d;

	logic [15:0] step_size_q, tolerance_q, max_duty_q, min_duty_q;
	logic [15:0] last_v_q, duty_now_q;
	logic signed [15:0] last_i_q;

	logic [15:0] v_q;
	logic signed [15:0] i_q;
	logic signed [16:0] dv_q, di_q;
	logic zero_v_q;
	dir_t dir_q;
	logic signed [52:0] prod_q;
	logic signed [34:0] acc_q, num_q;
	logic [15:0] stepped_q;

	logic out_valid_q;
	logic [15:0] out_duty_q;
	dir_t out_dir_q;

	logic sample_fire, out_busy;
	logic signed [16:0] dv_in, di_in;
	logic signed [34:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [52:0] mul_p;
	logic [16:0] dv_abs;
	logic signed [34:0] num_neg;
	logic [34:0] num_abs;
	logic lhs_lt;
	dir_t cmp_dir;
	logic [16:0] up_sum;
	logic [15:0] stepped_d, clamp_hi, clamped;

	assign sample.ready = (state_q == ST_IDLE);
	assign sample_fire = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;
	assign out_busy = out_valid_q && !result.ready;

	assign result.valid = out_valid_q;
	assign result.duty = out_duty_q;
	assign result.direction = out_dir_q;

	assign dv_in = $signed({1'b0, sample.bus_voltage_mv}) - $signed({1'b0, last_v_q});
	assign di_in = $signed({sample.current_ma[15], sample.current_ma})
		- $signed({last_i_q[15], last_i_q});

	assign dv_abs = dv_q[16] ? 17'(-dv_q) : 17'(dv_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_A: begin
				mul_a = $signed({{18{di_q[16]}}, di_q});
				mul_b = $signed({2'b00, v_q});
			end
			ST_MUL_B: begin
				mul_a = $signed({{19{i_q[15]}}, i_q});
				mul_b = $signed({dv_q[16], dv_q});
			end
			ST_MUL_C: begin
				mul_a = $signed({18'b0, dv_abs});
				mul_b = $signed({2'b00, v_q});
			end
			ST_MUL_D: begin
				mul_a = $signed({2'b00, prod_q[32:0]});
				mul_b = $signed({2'b00, tolerance_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign num_neg = -num_q;
	assign num_abs = num_q[34] ? num_neg : num_q;
	assign lhs_lt = {7'b0, num_abs, 8'b0} < {1'b0, prod_q[48:0]};

	always_comb begin
		if (lhs_lt || (num_q == '0)) begin
			cmp_dir = DIR_HOLD;
		end else if (num_q[34] == dv_q[16]) begin
			cmp_dir = DIR_UP;
		end else begin
			cmp_dir = DIR_DOWN;
		end
	end

	assign up_sum = {1'b0, duty_now_q} + {1'b0, step_size_q};

	always_comb begin
		case (dir_q)
			DIR_UP: stepped_d = up_sum[16] ? 16'hFFFF : up_sum[15:0];
			DIR_DOWN: stepped_d = (duty_now_q > step_size_q) ? duty_now_q - step_size_q : 16'd0;
			default: stepped_d = duty_now_q;
		endcase
	end

	assign clamp_hi = (stepped_q > max_duty_q) ? max_duty_q : stepped_q;
	assign clamped = zero_v_q ? duty_now_q : ((clamp_hi < min_duty_q) ? min_duty_q : clamp_hi);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_fire) begin
					if ((sample.bus_voltage_mv == '0) || (dv_in == '0)) begin
						state_d = ST_STEP;
					end else begin
						state_d = ST_MUL_A;
					end
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_MUL_C;
			ST_MUL_C: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_CMP;
			ST_CMP: state_d = ST_STEP;
			ST_STEP: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RST;
			tolerance_q <= TOLERANCE_RST;
			max_duty_q <= MAX_DUTY_RST;
			min_duty_q <= MIN_DUTY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STEP_SIZE: step_size_q <= cfg.data;
				REG_TOLERANCE: tolerance_q <= cfg.data;
				REG_MAX_DUTY: max_duty_q <= cfg.data;
				REG_MIN_DUTY: min_duty_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_v_q <= '0;
			last_i_q <= '0;
			duty_now_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_fire) begin
				last_v_q <= sample.bus_voltage_mv;
				last_i_q <= sample.current_ma;
			end
			if ((state_q == ST_DONE) && !out_busy) begin
				duty_now_q <= clamped;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			v_q <= sample.bus_voltage_mv;
			i_q <= sample.current_ma;
			dv_q <= dv_in;
			di_q <= di_in;
			zero_v_q <= (sample.bus_voltage_mv == '0);
			if ((sample.bus_voltage_mv == '0) || (di_in == '0)) begin
				dir_q <= DIR_HOLD;
			end else if (di_in[16]) begin
				dir_q <= DIR_DOWN;
			end else begin
				dir_q <= DIR_UP;
			end
		end
		case (state_q)
			ST_MUL_A, ST_MUL_C, ST_MUL_D: prod_q <= mul_p;
			ST_MUL_B: begin
				prod_q <= mul_p;
				acc_q <= prod_q[34:0];
			end
			default: ;
		endcase
		if (state_q == ST_MUL_C) begin
			num_q <= acc_q + prod_q[34:0];
		end
		if (state_q == ST_CMP) begin
			dir_q <= cmp_dir;
		end
		if (state_q == ST_STEP) begin
			stepped_q <= stepped_d;
		end
		if ((state_q == ST_DONE) && !out_busy) begin
			out_duty_q <= clamped;
			out_dir_q <= dir_q;
		end
	end

	`MPPT_ASSERT_NEXT(a_busy_after_accept, sample_fire, state_q != ST_IDLE,
		"sequencer still idle after a sample beat")
	`MPPT_ASSERT_NEXT(a_duty_only_in_done, state_q != ST_DONE, $stable(duty_now_q),
		"duty changed outside the final step")
	`MPPT_ASSERT_NEXT(a_result_loaded, (state_q == ST_DONE) && !out_busy, out_valid_q,
		"finished sample left no result")

endmodule
